@@ hdl/ate_pkg.sv @@
// ate_pkg: shared types and constants for the array table engine
// no dependencies
package ate_pkg;
  localparam int unsigned Depth = 32;
  localparam int unsigned IdxW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  localparam logic [2:0] ModeAppend  = 3'd0;
  localparam logic [2:0] ModeInsert  = 3'd1;
  localparam logic [2:0] ModeDelete  = 3'd2;
  localparam logic [2:0] ModeSort    = 3'd3;
  localparam logic [2:0] ModeSearch  = 3'd4;
  localparam logic [2:0] ModeDisplay = 3'd5;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StFull     = 3'd1;
  localparam logic [2:0] StBadPos   = 3'd2;
  localparam logic [2:0] StNotFound = 3'd3;
  localparam logic [2:0] StEmpty    = 3'd4;

  typedef struct packed {
    logic [2:0]         mode;
    logic [5:0]         position;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] item_value;
    logic [5:0]         item_position;
    logic [2:0]         status;
    logic               last;
  } rsp_t;
endpackage

@@ hdl/ate_front.sv @@
// ate_front: accepts requests and holds them in a two-entry queue
// depends on ate_pkg
module ate_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_stall_o,
  input  ate_pkg::req_t req_i,
  output logic          q_valid_o,
  input  logic          q_pop_i,
  output ate_pkg::req_t q_o
);
  ate_pkg::req_t buf_q [2];
  logic rd_q, wr_q;
  logic [1:0] cnt_q;
  logic push;

  assign req_stall_o = (cnt_q == 2'd2);
  // unused modes are dropped here, never reach the back end
  assign push = req_valid_i && !req_stall_o && (req_i.mode <= ate_pkg::ModeDisplay);
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_o = buf_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wr_q] <= req_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= 1'b0;
      wr_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (q_pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end
endmodule

@@ hdl/ate_back.sv @@
// ate_back: sequencer that runs one request over the entry memory
// depends on ate_pkg
module ate_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  output logic          q_pop_o,
  input  ate_pkg::req_t q_i,
  output logic          rsp_valid_o,
  input  logic          rsp_stall_i,
  output ate_pkg::rsp_t rsp_o
);
  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SRead  = 3'd1;
  localparam logic [2:0] SWait  = 3'd2;
  localparam logic [2:0] SExec  = 3'd3;
  localparam logic [2:0] SWrite = 3'd4;
  localparam logic [2:0] SDone  = 3'd5;
  localparam logic [2:0] SFlush = 3'd6;

  logic signed [31:0] mem [ate_pkg::Depth];
  logic signed [31:0] rdata_q;
  logic [ate_pkg::IdxW-1:0] raddr, waddr;
  logic signed [31:0] wdata;
  logic we;
  logic re;

  logic [2:0] st_q, st_d;
  ate_pkg::req_t cur_q, cur_d;
  logic [ate_pkg::CntW-1:0] cnt_q, cnt_d;
  logic [ate_pkg::CntW-1:0] i_q, i_d, j_q, j_d;
  logic signed [31:0] a_q, a_d;  // sort: entry i
  logic found_q, found_d;
  logic [5:0] pend_q, pend_d;    // search: match held until the next one
  logic ph_q, ph_d;              // sort: read i vs j
  logic rv_q, rv_d;
  ate_pkg::rsp_t r_q, r_d;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[raddr];
  end

  assign rsp_valid_o = rv_q;
  assign rsp_o = r_q;
  assign q_pop_o = (st_q == SIdle) && q_valid_i && !rv_q;

  function automatic ate_pkg::rsp_t mk(logic signed [31:0] v, logic [5:0] p,
                                       logic [2:0] s, logic l);
    ate_pkg::rsp_t r;
    r.item_value = v; r.item_position = p; r.status = s; r.last = l;
    return r;
  endfunction

  always_comb begin
    st_d = st_q; cur_d = cur_q; cnt_d = cnt_q; i_d = i_q; j_d = j_q;
    a_d = a_q; found_d = found_q; pend_d = pend_q; ph_d = ph_q; rv_d = rv_q; r_d = r_q;
    we = 1'b0; waddr = '0; wdata = '0; raddr = i_q[ate_pkg::IdxW-1:0]; re = 1'b0;
    if (rv_q && !rsp_stall_i) rv_d = 1'b0;
    unique case (st_q)
      SIdle: begin
        if (q_pop_o) begin
          cur_d = q_i;
          found_d = 1'b0;
          ph_d = 1'b0;
          st_d = SDone;
          unique case (q_i.mode)
            ate_pkg::ModeAppend: begin
              if (cnt_q == ate_pkg::CntW'(ate_pkg::Depth)) begin
                rv_d = 1'b1; r_d = mk('0, '0, ate_pkg::StFull, 1'b1);
              end else begin
                we = 1'b1; waddr = cnt_q[ate_pkg::IdxW-1:0]; wdata = q_i.value;
                cnt_d = cnt_q + 1'b1;
                rv_d = 1'b1; r_d = mk('0, '0, ate_pkg::StOk, 1'b1);
              end
            end
            ate_pkg::ModeInsert: begin
              if (cnt_q == ate_pkg::CntW'(ate_pkg::Depth)) begin
                rv_d = 1'b1; r_d = mk('0, '0, ate_pkg::StFull, 1'b1);
              end else if (q_i.position == '0 || q_i.position > cnt_q + 1'b1) begin
                rv_d = 1'b1; r_d = mk('0, '0, ate_pkg::StBadPos, 1'b1);
              end else begin
                i_d = cnt_q;  // walk down, moving entry i-1 to i
                st_d = SRead;
              end
            end
            ate_pkg::ModeDelete: begin
              if (q_i.position == '0 || q_i.position > cnt_q) begin
                rv_d = 1'b1; r_d = mk('0, '0, ate_pkg::StBadPos, 1'b1);
              end else begin
                i_d = q_i.position - 1'b1;
                st_d = SRead;
              end
            end
            ate_pkg::ModeSort: begin
              i_d = '0; j_d = ate_pkg::CntW'(1);
              st_d = SRead;
            end
            ate_pkg::ModeSearch: begin
              if (cnt_q == '0) begin
                rv_d = 1'b1; r_d = mk('0, '0, ate_pkg::StNotFound, 1'b1);
              end else begin
                i_d = '0; st_d = SRead;
              end
            end
            default: begin
              if (cnt_q == '0) begin
                rv_d = 1'b1; r_d = mk('0, '0, ate_pkg::StEmpty, 1'b1);
              end else begin
                i_d = '0; st_d = SRead;
              end
            end
          endcase
        end
      end
      SRead: begin
        // issue the memory read for this step, or end the walk or start the next sort row
        unique case (cur_q.mode)
          ate_pkg::ModeInsert: begin
            if (i_q == cur_q.position - 1'b1) begin
              we = 1'b1; waddr = i_q[ate_pkg::IdxW-1:0]; wdata = cur_q.value;
              cnt_d = cnt_q + 1'b1;
              st_d = SDone;
            end else begin
              raddr = ate_pkg::IdxW'(i_q - 1'b1); re = 1'b1; st_d = SWait;
            end
          end
          ate_pkg::ModeDelete: begin
            if (i_q + 1'b1 >= cnt_q) begin
              cnt_d = cnt_q - 1'b1; st_d = SDone;
            end else begin
              raddr = ate_pkg::IdxW'(i_q + 1'b1); re = 1'b1; st_d = SWait;
            end
          end
          ate_pkg::ModeSort: begin
            if (j_q >= cnt_q) begin
              if (i_q + ate_pkg::CntW'(2) >= cnt_q) st_d = SDone;
              else begin
                // next row reloads entry i first
                i_d = i_q + 1'b1; j_d = i_q + ate_pkg::CntW'(2); ph_d = 1'b0;
              end
            end else begin
              raddr = ph_q ? j_q[ate_pkg::IdxW-1:0] : i_q[ate_pkg::IdxW-1:0];
              re = 1'b1;
              st_d = SWait;
            end
          end
          default: begin
            raddr = i_q[ate_pkg::IdxW-1:0]; re = 1'b1; st_d = SWait;
          end
        endcase
        if (st_d == SDone && cur_q.mode != ate_pkg::ModeSearch) begin
          rv_d = 1'b1; r_d = mk('0, '0, ate_pkg::StOk, 1'b1);
        end
      end
      SWait: st_d = SExec;
      SExec: begin
        unique case (cur_q.mode)
          ate_pkg::ModeInsert: begin
            we = 1'b1; waddr = i_q[ate_pkg::IdxW-1:0]; wdata = rdata_q;
            i_d = i_q - 1'b1; st_d = SRead;
          end
          ate_pkg::ModeDelete: begin
            we = 1'b1; waddr = i_q[ate_pkg::IdxW-1:0]; wdata = rdata_q;
            i_d = i_q + 1'b1; st_d = SRead;
          end
          ate_pkg::ModeSort: begin
            if (!ph_q) begin
              a_d = rdata_q; ph_d = 1'b1; st_d = SRead;
            end else if (a_q > rdata_q) begin
              // swap: j gets old i now, i gets old j next cycle
              we = 1'b1; waddr = j_q[ate_pkg::IdxW-1:0]; wdata = a_q;
              a_d = rdata_q; st_d = SWrite;
            end else begin
              j_d = j_q + 1'b1; st_d = SRead;
            end
          end
          default: begin
            // display emits one result per step; search sends the previous match
            if (!rv_q || !rsp_stall_i) begin
              logic hit;
              logic fin;
              hit = (rdata_q == cur_q.value);
              fin = (i_q + 1'b1 >= cnt_q);
              if (cur_q.mode == ate_pkg::ModeDisplay) begin
                rv_d = 1'b1;
                r_d = mk(rdata_q, i_q + 1'b1, ate_pkg::StOk, fin);
              end else if (hit) begin
                if (found_q) begin
                  rv_d = 1'b1;
                  r_d = mk('0, pend_q, ate_pkg::StOk, 1'b0);
                end
                found_d = 1'b1;
                pend_d = i_q + 1'b1;
              end
              i_d = i_q + 1'b1;
              if (!fin) st_d = SRead;
              else if (cur_q.mode == ate_pkg::ModeDisplay) st_d = SDone;
              else st_d = SFlush;
            end
          end
        endcase
      end
      SWrite: begin
        we = 1'b1; waddr = i_q[ate_pkg::IdxW-1:0]; wdata = a_q;
        j_d = j_q + 1'b1; st_d = SRead;
      end
      SFlush: begin
        // search end: the held match is the final one, or nothing matched
        if (!rv_q || !rsp_stall_i) begin
          rv_d = 1'b1;
          r_d = found_q ? mk('0, pend_q, ate_pkg::StOk, 1'b1)
                        : mk('0, '0, ate_pkg::StNotFound, 1'b1);
          st_d = SDone;
        end
      end
      SDone: if (!rv_d) st_d = SIdle;
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; cnt_q <= '0; rv_q <= 1'b0; found_q <= 1'b0; ph_q <= 1'b0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; rv_q <= rv_d; found_q <= found_d; ph_q <= ph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d; i_q <= i_d; j_q <= j_d; a_q <= a_d; r_q <= r_d; pend_q <= pend_d;
  end
endmodule

@@ hdl/array_table_engine_core.sv @@
// array_table_engine_core: top level of the array table engine
// depends on ate_pkg, ate_front, ate_back
//
// usage: one request channel (req_valid_i, req_stall_o, req_i) carries mode,
// position and value; one response channel (rsp_valid_o, rsp_stall_i, rsp_o)
// carries item_value, item_position, status and last. last marks the final
// response of a request
// the front end queues up to two requests; the back end runs one request at
// a time against a 32-entry memory with registered read
// append and failed checks answer straight from idle; insert and delete
// move one entry per step, each step a read and a write; search and display
// read one entry per step, search one more step to send its final match;
// sort reads one entry per compare, rereads entry i at the start of each
// row and adds a write step per swap. each step that reads waits for the
// registered read data
// reset clears the queue and the entry count; memory contents are not
// cleared. a stalled response holds; the walk waits for it
// modes 6 and 7 are dropped without a response
module array_table_engine_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_stall_o,
  input  ate_pkg::req_t req_i,
  output logic          rsp_valid_o,
  input  logic          rsp_stall_i,
  output ate_pkg::rsp_t rsp_o
);
  logic q_valid, q_pop;
  ate_pkg::req_t q_req;

  // request queue
  ate_front u_front (
    .clk_i, .rst_ni, .req_valid_i, .req_stall_o, .req_i,
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_o(q_req)
  );

  // sequencer over the entry memory
  ate_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_pop_o(q_pop), .q_i(q_req),
    .rsp_valid_o, .rsp_stall_i, .rsp_o
  );
endmodule
